@@ sv/sha_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 shared definitions
// Constants, block-queue word type and the round helper functions.
// ----------------------------------------------------------------------------
package sha_pkg;

    localparam int QUEUE_DEPTH = 2;

    // One filled 512-bit block on its way to the round engine.
    typedef struct packed {
        logic [511:0] block;
        logic         final_blk;
    } t_blk;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROUND,
        ST_FOLD,
        ST_EMIT
    } t_core_state;

    function automatic logic [31:0] init_hash(input logic [2:0] i);
        logic [31:0] v;
        begin
            case (i)
                3'd0: v = 32'h6a09e667;
                3'd1: v = 32'hbb67ae85;
                3'd2: v = 32'h3c6ef372;
                3'd3: v = 32'ha54ff53a;
                3'd4: v = 32'h510e527f;
                3'd5: v = 32'h9b05688c;
                3'd6: v = 32'h1f83d9ab;
                default: v = 32'h5be0cd19;
            endcase
            return v;
        end
    endfunction

    function automatic logic [31:0] round_k(input logic [5:0] r);
        logic [31:0] k [64];
        begin
            k = '{
                32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
                32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
                32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
                32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
                32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
                32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
                32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
                32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
                32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
                32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
                32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
                32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
                32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
                32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
                32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
                32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
            return k[r];
        end
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage
`default_nettype wire

@@ sv/sha_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 front end
// Packs bytes into blocks, counts the bit length and appends the padding.
// ----------------------------------------------------------------------------
module sha_front
    import sha_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_push,
    output logic            o_full,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_has_byte,
    input  wire logic       i_last,
    output logic            o_blk_valid,
    output t_blk            o_blk,
    input  wire logic       i_blk_ready
);

    logic [511:0] r_block, n_block;
    logic [5:0]   r_pos, n_pos;
    logic [63:0]  r_len, n_len;
    logic         r_pad, n_pad;       // padding in progress
    logic         r_lenblk, n_lenblk; // 0x80 already placed
    logic         r_out_v, n_out_v;
    t_blk         r_out, n_out;

    // Accept while not padding and the output slot can take a block.
    assign o_full      = r_pad || (r_out_v && !i_blk_ready);
    assign o_blk_valid = r_out_v;
    assign o_blk       = r_out;

    always_comb begin
        logic slot_free;
        logic [511:0] blk;
        slot_free = !r_out_v || i_blk_ready;
        n_block  = r_block;
        n_pos    = r_pos;
        n_len    = r_len;
        n_pad    = r_pad;
        n_lenblk = r_lenblk;
        n_out_v  = r_out_v && !i_blk_ready;
        n_out    = r_out;
        blk      = r_block;
        if (!r_pad) begin
            // Normal byte intake.
            if (i_push && slot_free) begin
                if (i_has_byte) begin
                    blk[511 - {r_pos, 3'b000} -: 8] = i_data_byte;
                    n_len = r_len + 64'd8;
                    n_pos = r_pos + 6'd1;
                    if (r_pos == 6'd63) begin
                        n_out_v = 1'b1;
                        n_out   = '{block: blk, final_blk: 1'b0};
                    end
                end
                n_block = blk;
                if (i_last) n_pad = 1'b1;
            end
        end else if (slot_free) begin
            // Padding: one block per cycle while the output slot is free.
            if (!r_lenblk) begin
                blk[511 - {r_pos, 3'b000} -: 8] = 8'h80;
                for (int b = 0; b < 64; b++)
                    if (b > int'(r_pos)) blk[511 - 8*b -: 8] = 8'h00;
            end else begin
                blk = '0;
            end
            if (r_lenblk || r_pos < 6'd56) begin
                blk[63:0] = r_len;
                n_out_v  = 1'b1;
                n_out    = '{block: blk, final_blk: 1'b1};
                n_pad    = 1'b0;
                n_lenblk = 1'b0;
                n_len    = '0;
                n_pos    = '0;
            end else begin
                n_out_v  = 1'b1;
                n_out    = '{block: blk, final_blk: 1'b0};
                n_lenblk = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_len    <= '0;
            r_pad    <= 1'b0;
            r_lenblk <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_pos    <= n_pos;
            r_len    <= n_len;
            r_pad    <= n_pad;
            r_lenblk <= n_lenblk;
            r_out_v  <= n_out_v;
        end
        r_block <= n_block;
        r_out   <= n_out;
    end

endmodule
`default_nettype wire

@@ sv/sha_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 block queue
// Short FIFO of filled blocks between the front end and the round engine.
// ----------------------------------------------------------------------------
module sha_queue
    import sha_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_wr_valid,
    output logic      o_wr_ready,
    input  wire t_blk i_wr_data,
    output logic      o_rd_valid,
    output t_blk      o_rd_data,
    input  wire logic i_rd_ready
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_blk            r_mem [DEPTH];
    logic [AW-1:0]   r_wp, r_rp;
    logic [AW:0]     r_cnt;
    logic            wr, rd;

    assign o_wr_ready = r_cnt != (AW+1)'(DEPTH);
    assign o_rd_valid = r_cnt != '0;
    assign o_rd_data  = r_mem[r_rp];
    assign wr = i_wr_valid && o_wr_ready;
    assign rd = o_rd_valid && i_rd_ready;

    // Pointer and count update.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            if (rd) r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(wr) - (AW+1)'(rd);
        end
    end

    // Storage.
    always_ff @(posedge i_clk) begin
        if (wr) r_mem[r_wp] <= i_wr_data;
    end

endmodule
`default_nettype wire

@@ sv/sha_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 round engine
// Runs 64 rounds, one per cycle, folds into the hash and emits the digest.
// ----------------------------------------------------------------------------
module sha_core
    import sha_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_blk_valid,
    input  wire t_blk        i_blk,
    output logic             o_blk_ready,
    output logic             o_empty,
    input  wire logic        i_pop,
    output logic [31:0]      o_digest_word,
    output logic [2:0]       o_word_index,
    output logic             o_last_word
);

    t_core_state  r_state, n_state;
    logic [31:0]  r_h [8];
    logic [31:0]  r_v [8];
    logic [31:0]  r_w [16];
    logic [5:0]   r_rnd;
    logic [2:0]   r_idx;
    logic         r_final;

    assign o_blk_ready   = (r_state == ST_IDLE);
    assign o_empty       = (r_state != ST_EMIT);
    assign o_digest_word = r_h[r_idx];
    assign o_word_index  = r_idx;
    assign o_last_word   = (r_idx == 3'd7);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (i_blk_valid) n_state = ST_ROUND;
            ST_ROUND: if (r_rnd == 6'd63) n_state = ST_FOLD;
            ST_FOLD:  n_state = r_final ? ST_EMIT : ST_IDLE;
            ST_EMIT:  if (i_pop && r_idx == 3'd7) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else          r_state <= n_state;
    end

    // Round datapath; the schedule window shifts by one word per round.
    always_ff @(posedge i_clk) begin
        logic [31:0] w, t1, t2, s0, s1, g0, g1;
        g0 = rotr(r_w[1], 7) ^ rotr(r_w[1], 18) ^ (r_w[1] >> 3);
        g1 = rotr(r_w[14], 17) ^ rotr(r_w[14], 19) ^ (r_w[14] >> 10);
        w  = r_w[0];
        s1 = rotr(r_v[4], 6) ^ rotr(r_v[4], 11) ^ rotr(r_v[4], 25);
        t1 = r_v[7] + s1 + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
             + round_k(r_rnd) + w;
        s0 = rotr(r_v[0], 2) ^ rotr(r_v[0], 13) ^ rotr(r_v[0], 22);
        t2 = s0 + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
        if (!i_rst_n) begin
            for (int j = 0; j < 8; j++) r_h[j] <= init_hash(3'(j));
            r_idx <= '0;
            r_rnd <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (i_blk_valid) begin
                        for (int j = 0; j < 16; j++)
                            r_w[j] <= i_blk.block[511 - 32*j -: 32];
                        for (int j = 0; j < 8; j++) r_v[j] <= r_h[j];
                        r_final <= i_blk.final_blk;
                        r_rnd   <= '0;
                    end
                end
                ST_ROUND: begin
                    for (int j = 0; j < 15; j++) r_w[j] <= r_w[j+1];
                    r_w[15] <= r_w[0] + g0 + r_w[9] + g1;
                    r_v[7] <= r_v[6]; r_v[6] <= r_v[5]; r_v[5] <= r_v[4];
                    r_v[4] <= r_v[3] + t1;
                    r_v[3] <= r_v[2]; r_v[2] <= r_v[1]; r_v[1] <= r_v[0];
                    r_v[0] <= t1 + t2;
                    r_rnd  <= r_rnd + 6'd1;
                end
                ST_FOLD: begin
                    for (int j = 0; j < 8; j++) r_h[j] <= r_h[j] + r_v[j];
                    r_idx <= '0;
                end
                ST_EMIT: begin
                    if (i_pop) begin
                        r_idx <= r_idx + 3'd1;
                        if (r_idx == 3'd7)
                            for (int j = 0; j < 8; j++) r_h[j] <= init_hash(3'(j));
                    end
                end
                default: ;
            endcase
        end
    end

endmodule
`default_nettype wire

@@ sv/sha256_message_digest.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 message digest
// Byte-fed SHA-256 with padding; returns eight digest words per message.
// ----------------------------------------------------------------------------
// Bytes are taken one per cycle while full is low. Each filled 64-byte block
// passes through a two-entry block queue to a round engine that takes the
// block, runs the rounds and then folds it into the hash; the front end fills
// the next block meanwhile. The front end holds full while it pads a closing
// message, including the extra block when the tail needs one, and otherwise
// only when the queue and its output slot are both taken. Once the last block
// is folded the eight digest words are popped in order, most significant
// first, and the initial hash is reloaded; the engine takes no new block
// until all eight have been popped.
module sha256_message_digest
    import sha_pkg::*;
#(
    parameter int QDEPTH = QUEUE_DEPTH
)(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_has_byte,
    input  wire logic        i_last,
    output logic             empty,
    input  wire logic        pop,
    output logic [31:0]      o_digest_word,
    output logic [2:0]       o_word_index,
    output logic             o_last_word
);

    logic f_valid, f_ready, q_valid, q_ready;
    t_blk f_blk, q_blk;

    sha_front u_front (
        .i_clk, .i_rst_n, .i_push(push), .o_full(full),
        .i_data_byte, .i_has_byte, .i_last,
        .o_blk_valid(f_valid), .o_blk(f_blk), .i_blk_ready(f_ready)
    );

    sha_queue #(.DEPTH(QDEPTH)) u_queue (
        .i_clk, .i_rst_n,
        .i_wr_valid(f_valid), .o_wr_ready(f_ready), .i_wr_data(f_blk),
        .o_rd_valid(q_valid), .o_rd_data(q_blk), .i_rd_ready(q_ready)
    );

    sha_core u_core (
        .i_clk, .i_rst_n,
        .i_blk_valid(q_valid), .i_blk(q_blk), .o_blk_ready(q_ready),
        .o_empty(empty), .i_pop(pop),
        .o_digest_word, .o_word_index, .o_last_word
    );

endmodule
`default_nettype wire
